@@ rtl/core/itb_pkg.sv @@
`timescale 1ns / 1ps
package itb_pkg;

  localparam int unsigned BINS       = 256;
  localparam int unsigned BIN_W      = 8;
  localparam int unsigned COUNT_BITS = 25;
  localparam int unsigned MAX_ITER   = 64;
  localparam int unsigned ITER_W     = 9;
  localparam int unsigned CSUM_W     = COUNT_BITS + BIN_W;
  localparam int unsigned PROD_W     = COUNT_BITS + BIN_W;
  localparam int unsigned SSUM_W     = COUNT_BITS + 2 * BIN_W;
  localparam int unsigned COEF_W     = 12;
  localparam int unsigned MUL_W      = COEF_W + BIN_W;
  localparam int unsigned PADDR_W    = 3;

  localparam logic [COEF_W-1:0] COEF_RESET  = 12'd256;
  localparam logic [BIN_W-1:0]  GUESS_RESET = 8'd56;

  localparam logic [0:0] REG_COEF  = 1'b0;
  localparam logic [0:0] REG_GUESS = 1'b1;

  localparam logic KIND_THRESH = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;
  localparam logic REQ_HIST    = 1'b0;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_HRD   = 9'b000000100,
    ST_CHECK = 9'b000001000,
    ST_SWEEP = 9'b000010000,
    ST_DIVLD = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_MUL   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

endpackage

@@ rtl/core/itb_pix_if.sv @@
`timescale 1ns / 1ps
interface itb_pix_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel_value;
  logic       last;
  modport source (output valid, req_type, pixel_value, last, input ready);
  modport sink (input valid, req_type, pixel_value, last, output ready);
endinterface

@@ rtl/core/itb_res_if.sv @@
`timescale 1ns / 1ps
interface itb_res_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] threshold;
  logic       pixel_class;
  logic       last_out;
  modport source (output valid, out_kind, threshold, pixel_class, last_out, input ready);
  modport sink (input valid, out_kind, threshold, pixel_class, last_out, output ready);
endinterface

@@ rtl/core/itb_ram.sv @@
`timescale 1ns / 1ps
module itb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/core/isodata_threshold_binarizer_top.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    req_type, pixel_value, last
// out_o     out  valid/ready    out_kind, threshold, pixel_class, last_out
// apb       in   psel/penable   paddr, pwdata (write), prdata (read)
//
// Histogram pixel: read in ST_IDLE, written back in ST_HRD (read-modify-write on the histogram RAM port).
// Classification pixel: classified on acceptance in ST_IDLE. Threshold search: per
// round a 256-bin sweep plus pipeline drain (v1_q, v2_q) and two 8-step divisions,
// up to MAX_ITER rounds, then scaling in ST_MUL and output in ST_OUT.
// After reset and after the last classification pixel the histogram is
// cleared over all 256 bins; in_i.ready stays low meanwhile.
// A stalled result holds in the output register; further inputs wait on it.
module isodata_threshold_binarizer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  itb_pix_if.sink                       in_i,
  itb_res_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [itb_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  localparam int unsigned BW = itb_pkg::BIN_W;
  localparam int unsigned CW = itb_pkg::COUNT_BITS;

  itb_pkg::state_e st_q, st_d;

  logic [itb_pkg::COEF_W-1:0] coef_q;
  logic [BW-1:0]              guess_q;
  logic [BW-1:0]              active_q;

  logic [BW:0]   addr_q;
  logic [BW-1:0] pix_q;
  logic          last_q;
  logic          v1_q, v2_q;
  logic [BW-1:0] b1_q;
  logic          side_q;
  logic [itb_pkg::PROD_W-1:0] prod_q;
  logic [CW-1:0]              cnt_q;
  logic [itb_pkg::SSUM_W-1:0] slo_q, shi_q, rem_q;
  logic [itb_pkg::CSUM_W-1:0] clo_q, chi_q, dvs_q;
  logic [2:0]    dcnt_q;
  logic          hi_q;
  logic [BW-1:0] qacc_q, qlo_q, cur_q, prev_q;
  logic [itb_pkg::ITER_W-1:0] rounds_q;
  logic [itb_pkg::MUL_W-1:0]  mul_q;

  logic       out_v_q, out_kind_q, out_cls_q, out_last_q;
  logic [BW-1:0] out_thr_q;

  logic          ram_we;
  logic [BW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;

  logic out_free, in_acc, out_load, go_round;
  logic [itb_pkg::SSUM_W-1:0] trial;
  logic          trial_ok;
  logic [BW-1:0] qnew;
  logic [BW:0]   qsum;
  logic [BW-1:0] thr_sat;

  assign out_free = ~out_v_q | out_o.ready;
  assign in_i.ready = (st_q == itb_pkg::ST_IDLE) && out_free;
  assign in_acc = in_i.valid & in_i.ready;
  assign out_load = ((st_q == itb_pkg::ST_IDLE) && in_acc &&
                     (in_i.req_type != itb_pkg::REQ_HIST)) ||
                    ((st_q == itb_pkg::ST_OUT) && out_free);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == itb_pkg::REG_GUESS) ? {24'd0, guess_q}
                                                   : {20'd0, coef_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= itb_pkg::COEF_RESET;
      guess_q <= itb_pkg::GUESS_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == itb_pkg::REG_GUESS) begin
        guess_q <= pwdata[BW-1:0];
      end else begin
        coef_q <= pwdata[itb_pkg::COEF_W-1:0];
      end
    end
  end

  itb_ram #(.Width(CW), .Depth(itb_pkg::BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_we    = (st_q == itb_pkg::ST_HRD) || (st_q == itb_pkg::ST_CLEAR);
  assign ram_waddr = (st_q == itb_pkg::ST_HRD) ? pix_q : addr_q[BW-1:0];
  // saturating bin increment; clear pass writes zero
  assign ram_wdata = (st_q == itb_pkg::ST_CLEAR) ? '0 :
                     (&ram_rdata) ? ram_rdata : ram_rdata + CW'(1);
  assign ram_raddr = (st_q == itb_pkg::ST_IDLE) ? in_i.pixel_value : addr_q[BW-1:0];

  // one restoring-division step: quotient fits in BIN_W bits since mean <= 255
  assign trial    = itb_pkg::SSUM_W'(dvs_q) << dcnt_q;
  assign trial_ok = rem_q >= trial;
  assign qnew     = qacc_q | (trial_ok ? (BW'(1) << dcnt_q) : '0);
  assign qsum     = {1'b0, qlo_q} + {1'b0, qnew};
  assign go_round = (cur_q != prev_q) && (rounds_q < itb_pkg::ITER_W'(itb_pkg::MAX_ITER));
  assign thr_sat  = (|mul_q[itb_pkg::MUL_W-1:2*BW]) ? '1 : mul_q[2*BW-1:BW];

  always_comb begin
    st_d = st_q;
    case (st_q)
      itb_pkg::ST_CLEAR: if (addr_q[BW-1:0] == '1) st_d = itb_pkg::ST_IDLE;
      itb_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.req_type == itb_pkg::REQ_HIST) st_d = itb_pkg::ST_HRD;
          else if (in_i.last) st_d = itb_pkg::ST_CLEAR;
        end
      end
      itb_pkg::ST_HRD:   st_d = last_q ? itb_pkg::ST_CHECK : itb_pkg::ST_IDLE;
      itb_pkg::ST_CHECK: st_d = go_round ? itb_pkg::ST_SWEEP : itb_pkg::ST_MUL;
      itb_pkg::ST_SWEEP: if (addr_q[BW] && !v1_q && !v2_q) st_d = itb_pkg::ST_DIVLD;
      itb_pkg::ST_DIVLD: st_d = itb_pkg::ST_DIV;
      itb_pkg::ST_DIV: begin
        if (dcnt_q == 3'd0) st_d = hi_q ? itb_pkg::ST_CHECK : itb_pkg::ST_DIVLD;
      end
      itb_pkg::ST_MUL:   st_d = itb_pkg::ST_OUT;
      itb_pkg::ST_OUT:   if (out_free) st_d = itb_pkg::ST_IDLE;
      default:           st_d = itb_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= itb_pkg::ST_CLEAR;
      addr_q   <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      active_q <= '0;
      out_v_q  <= 1'b0;
      rounds_q <= '0;
      hi_q     <= 1'b0;
    end else begin
      st_q <= st_d;
      v1_q <= (st_q == itb_pkg::ST_SWEEP) && !addr_q[BW];
      v2_q <= v1_q;
      out_v_q <= out_load | (out_v_q & ~out_o.ready);
      case (st_q)
        itb_pkg::ST_CLEAR: addr_q <= (addr_q[BW-1:0] == '1) ? '0 : addr_q + 1'b1;
        itb_pkg::ST_IDLE: ;
        itb_pkg::ST_HRD: begin
          rounds_q <= '0;
        end
        itb_pkg::ST_CHECK: begin
          addr_q <= '0;
          if (go_round) rounds_q <= rounds_q + 1'b1;
        end
        itb_pkg::ST_SWEEP: if (!addr_q[BW]) addr_q <= addr_q + 1'b1;
        itb_pkg::ST_DIVLD: ;
        itb_pkg::ST_DIV: begin
          if (dcnt_q == 3'd0) hi_q <= ~hi_q;
        end
        itb_pkg::ST_MUL: ;
        itb_pkg::ST_OUT: begin
          if (out_free) active_q <= thr_sat;
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    b1_q   <= addr_q[BW-1:0];
    side_q <= b1_q < cur_q;
    prod_q <= itb_pkg::PROD_W'(ram_rdata) * itb_pkg::PROD_W'(b1_q);
    cnt_q  <= ram_rdata;
    if (st_q == itb_pkg::ST_SWEEP && v2_q) begin
      if (side_q) begin
        slo_q <= slo_q + itb_pkg::SSUM_W'(prod_q);
        clo_q <= clo_q + itb_pkg::CSUM_W'(cnt_q);
      end else begin
        shi_q <= shi_q + itb_pkg::SSUM_W'(prod_q);
        chi_q <= chi_q + itb_pkg::CSUM_W'(cnt_q);
      end
    end
    case (st_q)
      itb_pkg::ST_IDLE: begin
        if (in_acc) begin
          pix_q  <= in_i.pixel_value;
          last_q <= in_i.last;
          if (in_i.req_type != itb_pkg::REQ_HIST) begin
            out_kind_q <= itb_pkg::KIND_PIXEL;
            out_thr_q  <= active_q;
            out_cls_q  <= in_i.pixel_value <= active_q;
            out_last_q <= in_i.last;
          end
        end
      end
      itb_pkg::ST_HRD: begin
        cur_q  <= guess_q;
        prev_q <= '0;
      end
      itb_pkg::ST_CHECK: begin
        prev_q <= cur_q;
        slo_q  <= '0;
        shi_q  <= '0;
        clo_q  <= '0;
        chi_q  <= '0;
      end
      itb_pkg::ST_DIVLD: begin
        // empty side divides by one
        rem_q  <= hi_q ? shi_q : slo_q;
        dvs_q  <= hi_q ? ((chi_q == '0) ? itb_pkg::CSUM_W'(1) : chi_q)
                       : ((clo_q == '0) ? itb_pkg::CSUM_W'(1) : clo_q);
        dcnt_q <= 3'd7;
        qacc_q <= '0;
      end
      itb_pkg::ST_DIV: begin
        if (trial_ok) rem_q <= rem_q - trial;
        qacc_q <= qnew;
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == 3'd0) begin
          if (hi_q) cur_q <= qsum[BW:1];
          else qlo_q <= qnew;
        end
      end
      itb_pkg::ST_MUL: mul_q <= itb_pkg::MUL_W'(cur_q) * itb_pkg::MUL_W'(coef_q);
      itb_pkg::ST_OUT: begin
        if (out_free) begin
          out_kind_q <= itb_pkg::KIND_THRESH;
          out_thr_q  <= thr_sat;
          out_cls_q  <= 1'b0;
          out_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid       = out_v_q;
  assign out_o.out_kind    = out_kind_q;
  assign out_o.threshold   = out_thr_q;
  assign out_o.pixel_class = out_cls_q;
  assign out_o.last_out    = out_last_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> st_q == itb_pkg::ST_IDLE)
    else $error("input ready outside idle");
  a_rounds_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rounds_q <= itb_pkg::ITER_W'(itb_pkg::MAX_ITER))
    else $error("search ran past round limit");
  a_report_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_kind_q == itb_pkg::KIND_THRESH) |-> (!out_cls_q && out_last_q))
    else $error("malformed threshold report");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == itb_pkg::ST_OUT && out_v_q && !out_o.ready) |=> out_v_q)
    else $error("pending result lost");
endmodule
